FILE: hdl/lsa_pkg.sv
package lsa_pkg;

  // field widths
  localparam int SYM_W   = 8;
  localparam int SCORE_W = 8;
  localparam int CELL_W  = 13;
  localparam int SUM_W   = CELL_W + 2;
  localparam int REG_W   = 2;

  // default query depth
  localparam int DEF_MAX_QUERY = 64;

  // cell saturation and the gap character
  localparam logic [CELL_W-1:0] CELL_MAX   = 13'd8191;
  localparam logic [SYM_W-1:0]  GAP_SYMBOL = 8'd45;

  // item kinds carried in tuser
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_SUBJECT = 1'b1;

  // register indexes
  localparam logic [REG_W-1:0] REG_MATCH    = 2'd0;
  localparam logic [REG_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [REG_W-1:0] REG_GAP      = 2'd2;

  // register reset values
  localparam logic signed [SCORE_W-1:0] RST_MATCH    = 8'sd2;
  localparam logic signed [SCORE_W-1:0] RST_MISMATCH = -8'sd1;
  localparam logic signed [SCORE_W-1:0] RST_GAP      = -8'sd1;

  typedef struct packed {
    logic signed [SCORE_W-1:0] match_score;
    logic signed [SCORE_W-1:0] mismatch_score;
    logic signed [SCORE_W-1:0] gap_score;
  } score_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

endpackage

FILE: hdl/lsa_cell.sv
module lsa_cell import lsa_pkg::*; (
  input  score_cfg_t        cfg,
  input  logic [SYM_W-1:0]  q_sym,
  input  logic [SYM_W-1:0]  s_sym,
  input  logic [CELL_W-1:0] left_cell,
  input  logic [CELL_W-1:0] diag_cell,
  input  logic [CELL_W-1:0] up_cell,
  output logic [CELL_W-1:0] score
);

  logic signed [SCORE_W-1:0] pair;
  logic signed [SUM_W-1:0]   gap_ext;
  logic signed [SUM_W-1:0]   pair_ext;
  logic signed [SUM_W-1:0]   left_v;
  logic signed [SUM_W-1:0]   up_v;
  logic signed [SUM_W-1:0]   diag_v;
  logic signed [SUM_W-1:0]   best_v;

  // pair score of query and subject symbol
  always_comb begin
    if (q_sym == s_sym) begin
      pair = cfg.match_score;
    end else if (q_sym == GAP_SYMBOL || s_sym == GAP_SYMBOL) begin
      pair = cfg.gap_score;
    end else begin
      pair = cfg.mismatch_score;
    end
  end

  // three candidate scores
  assign gap_ext  = {{(SUM_W-SCORE_W){cfg.gap_score[SCORE_W-1]}}, cfg.gap_score};
  assign pair_ext = {{(SUM_W-SCORE_W){pair[SCORE_W-1]}}, pair};
  assign left_v   = $signed({2'b00, left_cell}) + gap_ext;
  assign up_v     = $signed({2'b00, up_cell}) + gap_ext;
  assign diag_v   = $signed({2'b00, diag_cell}) + pair_ext;

  // maximum with zero, then saturate
  always_comb begin
    best_v = '0;
    if (left_v > best_v) best_v = left_v;
    if (up_v > best_v) best_v = up_v;
    if (diag_v > best_v) best_v = diag_v;
    if (best_v > $signed({2'b00, CELL_MAX})) begin
      score = CELL_MAX;
    end else begin
      score = best_v[CELL_W-1:0];
    end
  end

endmodule

FILE: hdl/local_alignment_score.sv
// query item: taken whenever the block is idle
// subject item: a pass over the query rows, then the emit state when
//   it carries last; each row is one read-modify-write of the column memory
// result is registered onto m_tdata by the emit state after a last subject item
// rst (synchronous) restores default scores, empties the query, zeroes the best;
//   the column memory needs no clearing pass, its first pass reads it as zero
module local_alignment_score import lsa_pkg::*; #(
  parameter int MAX_QUERY = DEF_MAX_QUERY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // symbol [7:0]
  input  logic               s_tuser,   // op [0]
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,   // best_score [12:0], zero [15:13]
  input  logic               cfg_we,
  input  logic [REG_W-1:0]   cfg_index,
  input  logic [SCORE_W-1:0] cfg_data
);

  localparam int AW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int CW = $clog2(MAX_QUERY + 1);

  score_cfg_t        cfg;
  state_t            state;
  state_t            state_next;
  logic [CW-1:0]     qcount;
  logic [CW-1:0]     load_count;
  logic              query_done;
  logic              fresh;
  logic [AW-1:0]     j;
  logic [AW-1:0]     rd_addr;
  logic              last_idx;
  logic              accept;
  logic              q_we;
  logic              col_we;
  logic              run_start;
  logic              emit_go;
  logic [SYM_W-1:0]  sub_sym;
  logic              sub_last;
  logic [CELL_W-1:0] diag_prev;
  logic [CELL_W-1:0] up_cell;
  logic [CELL_W-1:0] best;
  logic [CELL_W-1:0] out_score;
  logic [SYM_W-1:0]  q_rd;
  logic [CELL_W-1:0] c_rd;
  logic [CELL_W-1:0] c_val;
  logic [CELL_W-1:0] new_score;

  logic [SYM_W-1:0]  query_mem [MAX_QUERY];
  logic [CELL_W-1:0] col_mem   [MAX_QUERY];

  // score registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{match_score: RST_MATCH, mismatch_score: RST_MISMATCH, gap_score: RST_GAP};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH:    cfg.match_score    <= cfg_data;
        REG_MISMATCH: cfg.mismatch_score <= cfg_data;
        REG_GAP:      cfg.gap_score      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept     = s_tvalid && s_tready;
  assign load_count = query_done ? '0 : qcount;
  assign q_we       = accept && (s_tuser == OP_LOAD) && (load_count < CW'(MAX_QUERY));
  assign run_start  = accept && (s_tuser == OP_SUBJECT) && query_done;
  assign last_idx   = (CW'(j) + CW'(1)) == qcount;
  assign c_val      = fresh ? '0 : c_rd;

  // sequencer: next state, ready, read address, column write and emit strobe
  always_comb begin
    state_next = state;
    s_tready   = (state == ST_IDLE);
    rd_addr    = '0;
    col_we     = 1'b0;
    emit_go    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (run_start) state_next = ST_RUN;
      end
      ST_RUN: begin
        col_we  = 1'b1;
        rd_addr = j + AW'(1);
        if (last_idx) state_next = sub_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          emit_go    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // query memory
  always_ff @(posedge clk) begin
    if (q_we) query_mem[load_count[AW-1:0]] <= s_tdata;
    q_rd <= query_mem[rd_addr];
  end

  // column memory, row j written while row j+1 is read
  always_ff @(posedge clk) begin
    if (col_we) col_mem[j] <= new_score;
    c_rd <= col_mem[rd_addr];
  end

  lsa_cell u_cell (
    .cfg       (cfg),
    .q_sym     (q_rd),
    .s_sym     (sub_sym),
    .left_cell (c_val),
    .diag_cell (diag_prev),
    .up_cell   (up_cell),
    .score     (new_score)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      qcount     <= '0;
      query_done <= 1'b0;
      fresh      <= 1'b1;
      best       <= '0;
      j          <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && s_tuser == OP_LOAD) begin
        qcount     <= q_we ? load_count + CW'(1) : load_count;
        query_done <= s_tlast;
        if (query_done) begin
          best  <= '0;
          fresh <= 1'b1;
        end
      end
      if (run_start) j <= '0;
      if (state == ST_RUN) begin
        j <= j + AW'(1);
        if (new_score > best) best <= new_score;
        if (last_idx) fresh <= 1'b0;
      end
      if (emit_go) begin
        m_tvalid <= 1'b1;
        best     <= '0;
        fresh    <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (run_start) begin
      sub_sym   <= s_tdata;
      sub_last  <= s_tlast;
      diag_prev <= '0;
      up_cell   <= '0;
    end
    if (state == ST_RUN) begin
      diag_prev <= c_val;
      up_cell   <= new_score;
    end
    if (emit_go) out_score <= best;
  end

  assign m_tdata = {3'b000, out_score};

  // a pass only runs over stored rows of a finished query
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (query_done && (CW'(j) < qcount)))
    else $error("row index outside the stored query");

  // a result only comes out of the emit step
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_EMIT))
    else $error("result raised outside emit");

  // after a full pass the column memory holds real values
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && last_idx) |=> !fresh)
    else $error("column still marked clear after a pass");

  // no item is taken while a pass is running
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && !last_idx) |=> (state == ST_RUN && !s_tready))
    else $error("pass interrupted");

endmodule

FILE: bench/local_alignment_score_checker.sv
`timescale 1ns / 1ps

module local_alignment_score_checker import lsa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [7:0]         s_tdata,   // symbol [7:0]
  input  logic               s_tuser,   // op [0]
  input  logic               s_tlast,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [15:0]        m_tdata,   // best_score [12:0], zero [15:13]
  input  logic               cfg_we,
  input  logic [REG_W-1:0]   cfg_index,
  input  logic [SCORE_W-1:0] cfg_data,
  output int                 failures,
  output int                 scores_waiting
);

  // scoring registers as seen by the predictor
  int match_pts;
  int mismatch_pts;
  int gap_pts;

  // predicted alignment state
  logic [SYM_W-1:0]  query_syms [DEF_MAX_QUERY];
  int                query_len;
  bit                query_closed;
  int                column [DEF_MAX_QUERY];
  int                best_so_far;
  logic [CELL_W-1:0] expected_best [$];
  logic [CELL_W-1:0] want_best;

  function automatic int pair_points(logic [SYM_W-1:0] a, logic [SYM_W-1:0] b);
    if (a == b) return match_pts;
    if (a == GAP_SYMBOL || b == GAP_SYMBOL) return gap_pts;
    return mismatch_pts;
  endfunction

  function automatic void clear_column();
    foreach (column[k]) column[k] = 0;
    best_so_far = 0;
  endfunction

  // one item: a query load or one column of cells for a subject symbol
  function automatic void predict_item(logic op, logic [SYM_W-1:0] sym, logic last);
    int diag_in;
    int above;
    int cell_score;
    int j;
    if (op == OP_LOAD) begin
      if (query_closed) begin
        query_closed = 1'b0;
        query_len = 0;
        clear_column();
      end
      if (query_len < DEF_MAX_QUERY) begin
        query_syms[query_len] = sym;
        query_len++;
      end
      if (last) query_closed = 1'b1;
      return;
    end
    // subject symbols before a complete query are dropped
    if (!query_closed) return;
    diag_in = 0;
    above = 0;
    for (j = 0; j < query_len; j++) begin
      cell_score = 0;
      if (column[j] + gap_pts > cell_score) cell_score = column[j] + gap_pts;
      if (above + gap_pts > cell_score) cell_score = above + gap_pts;
      if (diag_in + pair_points(query_syms[j], sym) > cell_score)
        cell_score = diag_in + pair_points(query_syms[j], sym);
      if (cell_score > int'(CELL_MAX)) cell_score = int'(CELL_MAX);
      diag_in = column[j];
      column[j] = cell_score;
      above = cell_score;
      if (cell_score > best_so_far) best_so_far = cell_score;
    end
    if (last) begin
      expected_best.push_back(best_so_far[CELL_W-1:0]);
      clear_column();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      match_pts = int'(RST_MATCH);
      mismatch_pts = int'(RST_MISMATCH);
      gap_pts = int'(RST_GAP);
      query_len = 0;
      query_closed = 1'b0;
      clear_column();
      expected_best.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_MATCH:    match_pts = int'($signed(cfg_data));
          REG_MISMATCH: mismatch_pts = int'($signed(cfg_data));
          REG_GAP:      gap_pts = int'($signed(cfg_data));
          default: ;
        endcase
      end
      // result items against the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_best.size() == 0) begin
          $error("best_score: no item expected, actual %0d", m_tdata[CELL_W-1:0]);
          failures++;
        end else begin
          want_best = expected_best.pop_front();
          if (m_tdata[CELL_W-1:0] !== want_best) begin
            $error("best_score: expected %0d, actual %0d", want_best, m_tdata[CELL_W-1:0]);
            failures++;
          end
        end
      end
      // input items
      if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata, s_tlast);
    end
    scores_waiting <= expected_best.size();
  end

endmodule

FILE: bench/local_alignment_score_test.sv
`timescale 1ns / 1ps

module local_alignment_score_test;
  import lsa_pkg::*;

  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 80;
  localparam int PRESSURE_PHASE = 5;
  localparam int LONG_HOLD      = 400;
  localparam int QUIET_CYCLES   = 2 * (DEF_MAX_QUERY + 4);
  localparam logic [SYM_W-1:0] BASES [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               s_tuser = OP_LOAD;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [15:0]        m_tdata;
  logic               cfg_we = 1'b0;
  logic [REG_W-1:0]   cfg_index = REG_MATCH;
  logic [SCORE_W-1:0] cfg_data = '0;

  int failures;
  int scores_waiting;
  bit calm = 1'b0;
  int hold_asks = 0;
  int hold_seen = 0;

  always #2 clk = ~clk;

  local_alignment_score DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  local_alignment_score_checker score_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .scores_waiting(scores_waiting)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // dna letters, gap symbols and the odd arbitrary byte
  function automatic logic [SYM_W-1:0] rand_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return SYM_W'($urandom_range(0, 255));
    if (r < 22) return GAP_SYMBOL;
    return BASES[$urandom_range(0, 3)];
  endfunction

  function automatic logic [SCORE_W-1:0] rand_points();
    if ($urandom_range(0, 99) < 30) return SCORE_W'($urandom_range(0, 255));
    return SCORE_W'(int'($urandom_range(0, 12)) - 6);
  endfunction

  // offer one item and wait until it is taken
  task automatic send_item(logic op, logic [SYM_W-1:0] sym, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= sym;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop offering, let every expected score drain, then let the block go idle
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (scores_waiting != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_W-1:0] idx, logic [SCORE_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_scores(int phase);
    logic [SCORE_W-1:0] m, mm, g;
    case (phase)
      0: begin m = 8'sd127;  mm = -8'sd128; g = -8'sd128; end
      1: begin m = -8'sd128; mm = 8'sd127;  g = 8'sd127;  end
      2: begin m = 8'sd127;  mm = 8'sd127;  g = -8'sd128; end
      3: begin m = -8'sd128; mm = -8'sd128; g = -8'sd128; end
      4: begin m = 8'sd127;  mm = 8'sd127;  g = 8'sd127;  end
      PRESSURE_PHASE: begin m = RST_MATCH; mm = RST_MISMATCH; g = RST_GAP; end
      default: begin m = rand_points(); mm = rand_points(); g = rand_points(); end
    endcase
    write_reg(REG_MATCH, m);
    write_reg(REG_MISMATCH, mm);
    write_reg(REG_GAP, g);
    cfg_we <= 1'b0;
  endtask

  // a query followed by a few subjects; a stray subject inside the query is not counted
  task automatic run_sequence(output int used);
    int r, qlen, nsub, slen, i, s;
    bit noisy;
    used = 0;
    r = $urandom_range(0, 99);
    if (r < 85) qlen = $urandom_range(1, 12);
    else if (r < 97) qlen = $urandom_range(13, DEF_MAX_QUERY);
    else qlen = $urandom_range(DEF_MAX_QUERY + 1, DEF_MAX_QUERY + 6);
    noisy = ($urandom_range(0, 99) < 10);
    for (i = 0; i < qlen; i++) begin
      // subject symbol inside an unfinished query
      if (noisy && i > 0 && i == qlen / 2)
        send_item(OP_SUBJECT, rand_symbol(), 1'($urandom_range(0, 1)));
      send_item(OP_LOAD, rand_symbol(), i == qlen - 1);
      used++;
    end
    nsub = $urandom_range(1, 4);
    for (s = 0; s < nsub; s++) begin
      slen = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 16) : $urandom_range(17, 40);
      for (i = 0; i < slen; i++) begin
        send_item(OP_SUBJECT, rand_symbol(), i == slen - 1);
        used++;
      end
    end
    // unfinished subject left for the next query load to clear
    if ($urandom_range(0, 99) < 15) begin
      slen = $urandom_range(1, 3);
      for (i = 0; i < slen; i++) begin
        send_item(OP_SUBJECT, rand_symbol(), 1'b0);
        used++;
      end
    end
  endtask

  // a result is held behind a stalled receiver until the input backs up
  task automatic fill_and_block();
    int i;
    calm = 1'b1;
    send_item(OP_LOAD, BASES[0], 1'b0);
    send_item(OP_LOAD, BASES[1], 1'b1);
    hold_asks++;
    for (i = 0; i < 24; i++) send_item(OP_SUBJECT, BASES[i % 4], 1'b1);
    settle();
  endtask

  // receiver side
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        m_tready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int phase, counted, used;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed items with the reset scores
    send_item(OP_SUBJECT, 8'h41, 1'b1);          // no query yet
    send_item(OP_LOAD, 8'h00, 1'b0);
    send_item(OP_LOAD, GAP_SYMBOL, 1'b0);
    send_item(OP_LOAD, 8'hFF, 1'b1);
    send_item(OP_SUBJECT, 8'h00, 1'b0);
    send_item(OP_SUBJECT, GAP_SYMBOL, 1'b0);     // gap against gap
    send_item(OP_SUBJECT, 8'hFF, 1'b1);
    send_item(OP_SUBJECT, 8'hFF, 1'b0);
    send_item(OP_SUBJECT, 8'h41, 1'b1);
    send_item(OP_SUBJECT, GAP_SYMBOL, 1'b1);
    send_item(OP_SUBJECT, 8'h00, 1'b0);          // column left dirty
    send_item(OP_LOAD, 8'h41, 1'b0);             // new query clears it
    send_item(OP_LOAD, 8'h43, 1'b1);
    send_item(OP_SUBJECT, 8'h41, 1'b0);
    send_item(OP_SUBJECT, 8'h43, 1'b1);
    send_item(OP_LOAD, 8'h47, 1'b1);             // one-symbol query
    send_item(OP_SUBJECT, 8'h47, 1'b1);
    send_item(OP_SUBJECT, 8'h54, 1'b1);
    settle();

    // random phases, each under its own scores
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      set_scores(phase);
      if (phase == PRESSURE_PHASE) fill_and_block();
      calm = (phase % 3 == 2);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        run_sequence(used);
        counted += used;
      end
      settle();
    end

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: local_alignment_score.f
hdl/lsa_pkg.sv
hdl/lsa_cell.sv
hdl/local_alignment_score.sv
bench/local_alignment_score_checker.sv
bench/local_alignment_score_test.sv
